[hw/rtl/stsg_pkg.sv]
package stsg_pkg;

  // Field widths of the channels.
  localparam int SAMPLE_W   = 12;
  localparam int SUM_W      = 18;
  localparam int COL_W      = 9;
  localparam int ROW_W      = 8;
  localparam int COLOR_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Parameter defaults.
  localparam int DECIMATION_DEF   = 7;
  localparam int SCREEN_WIDTH_DEF = 320;

  // Display geometry and converter scale.
  localparam int ADC_MID  = 2048;
  localparam int ROW_MID  = 120;
  localparam int ROW_LAST = 239;

  // Register reset values.
  localparam logic [COLOR_W-1:0] TRACE_COLOR_RST = 16'h07E0;
  localparam logic [COL_W-1:0]   ERASE_GAP_RST   = 9'd5;
  localparam logic [ROW_W-1:0]   TOP_LIMIT_RST   = 8'd51;

  // Register indices on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRACE_COLOR = 2'd0,
    CFG_ERASE_GAP   = 2'd1,
    CFG_TOP_LIMIT   = 2'd2
  } cfg_reg_t;

  // Handshake between the averaging stage and the plotting stage.
  typedef struct packed {
    logic valid;
    logic [SAMPLE_W-1:0] avg;
  } avg_beat_t;

endpackage

[hw/rtl/stsg_decim.sv]
module stsg_decim
  import stsg_pkg::*;
#(
  parameter int DECIMATION = DECIMATION_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_sample,
  output avg_beat_t           avg_o,
  input  logic                avg_stall
);

  // Exact reciprocal for any dividend below 2**SUM_W.
  localparam int DIV_K = SUM_W + $clog2(DECIMATION);
  localparam longint unsigned DIV_M_FULL =
    ((64'd1 << DIV_K) + 64'(DECIMATION) - 64'd1) / 64'(DECIMATION);
  localparam int PROD_W = 2 * SUM_W + 1;
  localparam logic [SUM_W:0] DIV_M = (SUM_W + 1)'(DIV_M_FULL);
  localparam int CNT_W = $clog2(DECIMATION + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DECIMATION - 1);

  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                a_valid_r, a_valid_nxt;
  logic [SAMPLE_W-1:0] a_avg_r, a_avg_nxt;
  logic [SUM_W-1:0]    group_sum;
  logic [PROD_W-1:0]   quot_prod;
  logic                accept, last;

  assign in_stall  = a_valid_r && avg_stall;
  assign accept    = in_valid && !in_stall;
  assign last      = (cnt_r == CNT_LAST);
  assign group_sum = sum_r + SUM_W'(in_sample);
  assign quot_prod = PROD_W'(group_sum) * PROD_W'(DIV_M);

  always_comb begin
    sum_nxt     = sum_r;
    cnt_nxt     = cnt_r;
    a_valid_nxt = a_valid_r && avg_stall;
    a_avg_nxt   = a_avg_r;
    if (accept) begin
      if (last) begin
        sum_nxt     = '0;
        cnt_nxt     = '0;
        a_valid_nxt = 1'b1;
        a_avg_nxt   = SAMPLE_W'(quot_prod >> DIV_K);
      end else begin
        sum_nxt = group_sum;
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      cnt_r     <= '0;
      a_valid_r <= 1'b0;
    end else begin
      sum_r     <= sum_nxt;
      cnt_r     <= cnt_nxt;
      a_valid_r <= a_valid_nxt;
    end
    a_avg_r <= a_avg_nxt;
  end

  assign avg_o.valid = a_valid_r;
  assign avg_o.avg   = a_avg_r;

endmodule

[hw/rtl/stsg_plot.sv]
module stsg_plot
  import stsg_pkg::*;
#(
  parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  avg_beat_t          avg_i,
  output logic               avg_stall,
  input  logic [COLOR_W-1:0] trace_color,
  input  logic [COL_W-1:0]   gap_mod,
  input  logic [ROW_W-1:0]   top_limit,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COL_W-1:0]   out_erase_column,
  output logic [COL_W-1:0]   out_draw_column,
  output logic [ROW_W-1:0]   out_span_top,
  output logic [ROW_W-1:0]   out_span_bottom,
  output logic [COLOR_W-1:0] out_segment_color
);

  localparam int SHIFT = $clog2(ADC_MID);
  localparam logic signed [12:0] CENTRE   = 13'(ADC_MID);
  localparam logic signed [19:0] SCALE    = 20'(ROW_MID);
  localparam logic signed [19:0] RND      = 20'(ADC_MID - 1);
  localparam logic signed [9:0]  ROW_BASE = 10'(ROW_MID);
  localparam logic signed [9:0]  ROW_MAX  = 10'(ROW_LAST);
  localparam logic [COL_W:0]     WIDTH_X  = (COL_W + 1)'(SCREEN_WIDTH);
  localparam logic [COL_W-1:0]   COL_LAST = COL_W'(SCREEN_WIDTH - 1);

  logic                 load;
  logic                 out_valid_r;
  logic [COL_W-1:0]     pen_r, pen_nxt;
  logic [ROW_W-1:0]     prev_row_r;
  logic [COL_W-1:0]     erase_r, erase_nxt;
  logic [COL_W-1:0]     draw_r;
  logic [ROW_W-1:0]     top_r, top_nxt, bot_r, bot_nxt;
  logic [COLOR_W-1:0]   color_r;
  logic signed [12:0]   centred;
  logic signed [19:0]   scaled, biased;
  logic signed [8:0]    offset;
  logic signed [9:0]    row_raw, row_lo, row_cl, top_s;
  logic [ROW_W-1:0]     row;
  logic [COL_W:0]       erase_sum;

  assign avg_stall = out_valid_r && out_stall;
  assign load      = avg_i.valid && !avg_stall;

  // Row mapping: the scaled offset divides by a power of two, rounded toward zero.
  always_comb begin
    centred = $signed({1'b0, avg_i.avg}) - CENTRE;
    scaled  = 20'(centred) * SCALE;
    biased  = scaled[19] ? scaled + RND : scaled;
    offset  = 9'(biased >>> SHIFT);
    row_raw = ROW_BASE - 10'(offset);
    top_s   = $signed({2'b00, top_limit});
    row_lo  = (row_raw < top_s) ? top_s : row_raw;
    row_cl  = (row_lo > ROW_MAX) ? ROW_MAX : row_lo;
    row     = ROW_W'(row_cl);
  end

  always_comb begin
    top_nxt   = (prev_row_r < row) ? prev_row_r : row;
    bot_nxt   = (prev_row_r < row) ? row : prev_row_r;
    erase_sum = (COL_W + 1)'(pen_r) + (COL_W + 1)'(gap_mod);
    erase_nxt = (erase_sum >= WIDTH_X) ? COL_W'(erase_sum - WIDTH_X) : COL_W'(erase_sum);
    pen_nxt   = (pen_r == COL_LAST) ? '0 : pen_r + COL_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pen_r       <= '0;
      prev_row_r  <= ROW_W'(ROW_MID);
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        pen_r       <= pen_nxt;
        prev_row_r  <= row;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (load) begin
      erase_r <= erase_nxt;
      draw_r  <= pen_r;
      top_r   <= top_nxt;
      bot_r   <= bot_nxt;
      color_r <= trace_color;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_erase_column  = erase_r;
  assign out_draw_column   = draw_r;
  assign out_span_top      = top_r;
  assign out_span_bottom   = bot_r;
  assign out_segment_color = color_r;

endmodule

[hw/rtl/sweep_trace_segment_generator_unit.sv]
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  sample (12 bits)
// out_      output     out_valid/out_stall  erase_column, draw_column, span_top,
//                                           span_bottom, segment_color
// cfg_      input      cfg_valid/cfg_ready  cfg_index (2 bits), cfg_data (16 bits)
//
// A sample transaction can be taken in every clock cycle while in_stall is low.
// The transaction that completes a group has its average, from the reciprocal
// multiplier, registered in the averaging stage at the edge that accepts it;
// the row mapping and column logic then load it into the result register,
// unless that register holds a stalled result, and offer the result transaction.
// Reset is synchronous and active low; it restores the register defaults, an
// empty group, pen column zero and previous row 120.
// A stalled result holds its register and the averaging stage then holds its
// average; in_stall follows out_stall only while both stages are full.
module sweep_trace_segment_generator_unit
  import stsg_pkg::*;
#(
  parameter int DECIMATION   = DECIMATION_DEF,
  parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   in_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COL_W-1:0]      out_erase_column,
  output logic [COL_W-1:0]      out_draw_column,
  output logic [ROW_W-1:0]      out_span_top,
  output logic [ROW_W-1:0]      out_span_bottom,
  output logic [COLOR_W-1:0]    out_segment_color,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // The erase gap is reduced modulo the screen width once, after a write, so
  // the result stage needs only one compare and subtract. The reduction uses
  // an exact reciprocal for nine-bit values: quotient first, then remainder,
  // each in its own register. Both are settled before the first average of a
  // new group can reach the result stage.
  localparam int GAP_K = COL_W + $clog2(SCREEN_WIDTH);
  localparam int GAP_PW = 2 * COL_W + 1;
  localparam longint unsigned GAP_M_FULL =
    ((64'd1 << GAP_K) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH);
  localparam logic [GAP_PW-1:0] GAP_M = GAP_PW'(GAP_M_FULL);
  localparam logic [GAP_PW-1:0] WIDTH_P = GAP_PW'(SCREEN_WIDTH);
  localparam logic [COL_W-1:0] GAP_MOD_RST = COL_W'(ERASE_GAP_RST % SCREEN_WIDTH);
  localparam logic [COL_W-1:0] GAP_Q_RST = COL_W'(ERASE_GAP_RST / SCREEN_WIDTH);

  logic [COLOR_W-1:0] color_r;
  logic [COL_W-1:0]   gap_r;
  logic [COL_W-1:0]   gap_q_r, gap_q_nxt;
  logic [COL_W-1:0]   gap_mod_r, gap_mod_nxt;
  logic [ROW_W-1:0]   top_limit_r;
  logic [GAP_PW-1:0]  gap_prod, gap_back;
  logic               cfg_write;
  avg_beat_t          avg_beat;
  logic               avg_stall;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  assign gap_prod    = GAP_PW'(cfg_data[COL_W-1:0]) * GAP_M;
  assign gap_q_nxt   = COL_W'(gap_prod >> GAP_K);
  assign gap_back    = GAP_PW'(gap_q_r) * WIDTH_P;
  assign gap_mod_nxt = gap_r - gap_back[COL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r     <= TRACE_COLOR_RST;
      gap_r       <= ERASE_GAP_RST;
      gap_q_r     <= GAP_Q_RST;
      gap_mod_r   <= GAP_MOD_RST;
      top_limit_r <= TOP_LIMIT_RST;
    end else begin
      gap_mod_r <= gap_mod_nxt;
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          CFG_TRACE_COLOR: color_r <= cfg_data;
          CFG_ERASE_GAP: begin
            gap_r   <= cfg_data[COL_W-1:0];
            gap_q_r <= gap_q_nxt;
          end
          CFG_TOP_LIMIT: top_limit_r <= cfg_data[ROW_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Group accumulation and the division by DECIMATION.
  stsg_decim #(
    .DECIMATION(DECIMATION)
  ) u_decim (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .avg_o     (avg_beat),
    .avg_stall (avg_stall)
  );

  // Row mapping, span, pen column and the result register.
  stsg_plot #(
    .SCREEN_WIDTH(SCREEN_WIDTH)
  ) u_plot (
    .clk               (clk),
    .rst_n             (rst_n),
    .avg_i             (avg_beat),
    .avg_stall         (avg_stall),
    .trace_color       (color_r),
    .gap_mod           (gap_mod_r),
    .top_limit         (top_limit_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_erase_column  (out_erase_column),
    .out_draw_column   (out_draw_column),
    .out_span_top      (out_span_top),
    .out_span_bottom   (out_span_bottom),
    .out_segment_color (out_segment_color)
  );

endmodule

[hw/rtl/stsg_checker.sv]
module stsg_checker
  import stsg_pkg::*;
#(
  parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [COL_W-1:0]   out_erase_column,
  input logic [COL_W-1:0]   out_draw_column,
  input logic [ROW_W-1:0]   out_span_top,
  input logic [ROW_W-1:0]   out_span_bottom,
  input logic [COLOR_W-1:0] out_segment_color
);

  localparam logic [COL_W:0] WIDTH_X = (COL_W + 1)'(SCREEN_WIDTH);
  localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(ROW_LAST);

  // No result survives a reset.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid directly after reset");

  // A stalled result stays offered and unchanged.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_erase_column)
      && $stable(out_draw_column) && $stable(out_span_top)
      && $stable(out_span_bottom) && $stable(out_segment_color))
    else $error("stalled result changed");

  // Both columns lie on the screen.
  a_columns_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((COL_W + 1)'(out_erase_column) < WIDTH_X)
      && ((COL_W + 1)'(out_draw_column) < WIDTH_X))
    else $error("column outside the screen");

  // The span is ordered and ends on or above the last row.
  a_span_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_span_top <= out_span_bottom) && (out_span_bottom <= ROW_MAX))
    else $error("span out of order or below the last row");

endmodule

bind sweep_trace_segment_generator_unit stsg_checker #(
  .SCREEN_WIDTH(SCREEN_WIDTH)
) u_stsg_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_erase_column  (out_erase_column),
  .out_draw_column   (out_draw_column),
  .out_span_top      (out_span_top),
  .out_span_bottom   (out_span_bottom),
  .out_segment_color (out_segment_color)
);

[sim/tb_top.sv]
module tb_top;
  import stsg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The block is built with its default geometry, and the local copy of the
  // plotting behaviour below uses the same two numbers.
  localparam int DECIM  = DECIMATION_DEF;
  localparam int SCREEN = SCREEN_WIDTH_DEF;

  // A sample that completes a group passes the averaging register on its way to
  // the result register. A settling pause is also allowed before a register is
  // written, so that nothing is still on its way through the block.
  localparam int PIPE_CYCLES = 6;

  // The run is ended by force after this many clock cycles. The slowest
  // correct run (long sender gaps, long receiver stalls and a settling pause
  // before every register write) needs a small fraction of it.
  localparam int CYCLE_LIMIT = 400000;

  // The configuration port has a fourth index that maps to no register.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct {
    logic [COL_W-1:0]   erase_column;
    logic [COL_W-1:0]   draw_column;
    logic [ROW_W-1:0]   span_top;
    logic [ROW_W-1:0]   span_bottom;
    logic [COLOR_W-1:0] segment_color;
  } segment_t;

  // Every input is given a known value from time zero onwards.
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   in_sample = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [COL_W-1:0]      out_erase_column;
  logic [COL_W-1:0]      out_draw_column;
  logic [ROW_W-1:0]      out_span_top;
  logic [ROW_W-1:0]      out_span_bottom;
  logic [COLOR_W-1:0]    out_segment_color;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Local copy of the block's registers and state, updated as transactions
  // are accepted.
  logic [COLOR_W-1:0] trace_color_q;
  logic [COL_W-1:0]   erase_gap_q;
  logic [ROW_W-1:0]   top_limit_q;
  logic [SUM_W-1:0]   group_sum_q;
  int                 group_fill_q;
  int                 pen_column_q;
  int                 last_row_q;

  // Segments that have been worked out but have not yet come out of the
  // block, oldest first.
  segment_t pending_segments[$];
  segment_t want_seg;

  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int err_count    = 0;
  int cycle_count  = 0;
  int sweep_level  = ADC_MID;

  sweep_trace_segment_generator_unit #(
    .DECIMATION   (DECIM),
    .SCREEN_WIDTH (SCREEN)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_erase_column  (out_erase_column),
    .out_draw_column   (out_draw_column),
    .out_span_top      (out_span_top),
    .out_span_bottom   (out_span_bottom),
    .out_segment_color (out_segment_color),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: a run that hangs is ended here as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL sweep_trace_segment_generator_unit");
      $finish;
    end
  end

  // The result side stalls at random, with the rate set per phase. All
  // inputs change on the falling edge so that nothing races the rising edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  // Each result transaction is compared with the oldest segment still waiting.
  // Sampling on the rising edge sees the values from before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_segments.size() == 0) begin
        report_mismatch($sformatf("result at column %0d with nothing expected",
                                  out_draw_column));
      end else begin
        want_seg = pending_segments.pop_front();
        check_field("erase_column", 32'(out_erase_column),
                    32'(want_seg.erase_column));
        check_field("draw_column", 32'(out_draw_column),
                    32'(want_seg.draw_column));
        check_field("span_top", 32'(out_span_top), 32'(want_seg.span_top));
        check_field("span_bottom", 32'(out_span_bottom),
                    32'(want_seg.span_bottom));
        check_field("segment_color", 32'(out_segment_color),
                    32'(want_seg.segment_color));
      end
    end
  end

  // Register state after reset: default registers, an empty group, the pen at
  // the left edge and the previous point on the centre row.
  task automatic reset_plot_state();
    trace_color_q = TRACE_COLOR_RST;
    erase_gap_q   = ERASE_GAP_RST;
    top_limit_q   = TOP_LIMIT_RST;
    group_sum_q   = '0;
    group_fill_q  = 0;
    pen_column_q  = 0;
    last_row_q    = ROW_MID;
  endtask

  // Adds one accepted sample to the running group. When the group is full,
  // its truncated average is turned into a row (the division rounds toward
  // zero, as signed integer division does), clamped to the top limit first
  // and to the bottom row second, and the segment for that step is queued.
  task automatic predict_segment(input logic [SAMPLE_W-1:0] sample);
    int       avg;
    int       centred;
    int       row;
    segment_t seg;
    group_sum_q  = group_sum_q + SUM_W'(sample);
    group_fill_q = group_fill_q + 1;
    if (group_fill_q < DECIM) return;
    avg          = int'(group_sum_q) / DECIM;
    group_sum_q  = '0;
    group_fill_q = 0;
    centred = avg - ADC_MID;
    row     = ROW_MID - (centred * ROW_MID) / ADC_MID;
    if (row < int'(top_limit_q)) row = int'(top_limit_q);
    if (row > ROW_LAST) row = ROW_LAST;
    seg.erase_column  = COL_W'((pen_column_q + int'(erase_gap_q)) % SCREEN);
    seg.draw_column   = COL_W'(pen_column_q);
    seg.span_top      = ROW_W'((last_row_q < row) ? last_row_q : row);
    seg.span_bottom   = ROW_W'((last_row_q < row) ? row : last_row_q);
    seg.segment_color = trace_color_q;
    pending_segments.push_back(seg);
    last_row_q   = row;
    pen_column_q = (pen_column_q + 1 >= SCREEN) ? 0 : pen_column_q + 1;
  endtask

  task automatic set_idling(input int in_pct, input int out_pct);
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
  endtask

  // Sends one sample transaction. The valid line is only lowered when the
  // sender decides to pause, so back-to-back samples keep it high, and it is
  // assigned at most once per falling edge.
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= sample;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_segment(sample);
  endtask

  // Stops sending, waits for every outstanding segment and then lets the
  // pipeline settle, since a sample that does not finish a group leaves
  // nothing to wait for.
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_segments.size() != 0) @(negedge clk);
    repeat (PIPE_CYCLES) @(negedge clk);
  endtask

  // Writes one register while the block is idle and mirrors the write in the
  // local copy. Only the low bits that fit a register are kept, and the spare
  // index changes nothing.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    drain_pipeline();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_TRACE_COLOR: trace_color_q = data[COLOR_W-1:0];
      CFG_ERASE_GAP:   erase_gap_q   = data[COL_W-1:0];
      CFG_TOP_LIMIT:   top_limit_q   = data[ROW_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // A mix of sample values: the rails, values close to mid-scale where the
  // rounding direction of the row mapping shows, a level that is drawn anew for
  // each group so that the trace moves up and down, and plain noise.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int v;
    case ($urandom_range(9))
      0:       v = 0;
      1:       v = (1 << SAMPLE_W) - 1;
      2:       v = ADC_MID + $urandom_range(127) - 64;
      3, 4, 5: v = sweep_level + $urandom_range(63) - 32;
      default: v = $urandom_range((1 << SAMPLE_W) - 1);
    endcase
    if (v < 0) v = 0;
    if (v > (1 << SAMPLE_W) - 1) v = (1 << SAMPLE_W) - 1;
    return v[SAMPLE_W-1:0];
  endfunction

  // Sends the given number of whole groups of random samples.
  task automatic run_groups(input int groups);
    for (int g = 0; g < groups; g++) begin
      sweep_level = $urandom_range((1 << SAMPLE_W) - 1);
      for (int s = 0; s < DECIM; s++) begin
        send_sample(pick_sample());
      end
    end
  endtask

  // Rails and rounding. A group of zeros maps below the screen and is held on
  // the bottom row; a group at full scale maps above the top limit and is
  // held there. A group sitting just below mid-scale lands one row under the
  // centre only if the division rounds toward zero. Three further samples, two
  // with alternating bit patterns and one all ones, leave a group partly filled,
  // to be finished by the following test.
  task automatic test_directed_rails();
    for (int s = 0; s < DECIM; s++) send_sample('0);
    for (int s = 0; s < DECIM; s++) send_sample('1);
    for (int s = 0; s < DECIM; s++) send_sample(SAMPLE_W'(ADC_MID - 18));
    send_sample(12'hAAA);
    send_sample(12'h555);
    send_sample(12'hFFF);
  endtask

  // Every register at both ends of its range, with data words that carry set bits
  // above the gap and top limit widths so that masking is seen.
  task automatic test_register_extremes();
    // Everything at zero: black trace, no erase gap, no upper clamp at all.
    write_reg(CFG_TRACE_COLOR, 16'h0000);
    write_reg(CFG_ERASE_GAP, 16'hFE00);
    write_reg(CFG_TOP_LIMIT, 16'hFF00);
    run_groups(8);
    // Everything at its top: the gap exceeds the screen width and wraps, and
    // a top limit past the last row pins every point to that row.
    write_reg(CFG_TRACE_COLOR, 16'hFFFF);
    write_reg(CFG_ERASE_GAP, 16'hFFFF);
    write_reg(CFG_TOP_LIMIT, 16'hFFFF);
    run_groups(8);
    // Largest in-range gap and the last row as the limit; a write to the
    // spare index must leave all of this untouched.
    write_reg(CFG_ERASE_GAP, 16'(SCREEN - 1));
    write_reg(CFG_TOP_LIMIT, 16'(ROW_LAST));
    write_reg(CFG_SPARE_IDX, 16'h5A5A);
    run_groups(8);
    // A random colour, the smallest in-range gap, the default top limit again and another spare write.
    write_reg(CFG_TRACE_COLOR, 16'($urandom_range(16'hFFFF)));
    write_reg(CFG_ERASE_GAP, 16'd1);
    write_reg(CFG_TOP_LIMIT, 16'(TOP_LIMIT_RST));
    write_reg(CFG_SPARE_IDX, 16'hFFFF);
    run_groups(8);
  endtask

  // Long random sweeps with the given idling. The registers are rewritten
  // every so often, either with a value inside the usable range or with a
  // fully random data word.
  task automatic test_random_sweep(input int in_pct, input int out_pct,
                                   input int groups);
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    set_idling(in_pct, out_pct);
    for (int g = 0; g < groups; g++) begin
      if (g % 12 == 11) begin
        idx = CFG_IDX_W'($urandom_range(3));
        if ($urandom_range(1)) begin
          data = CFG_DATA_W'($urandom_range(16'hFFFF));
        end else begin
          case (idx)
            CFG_ERASE_GAP: data = CFG_DATA_W'($urandom_range(SCREEN - 1, 1));
            CFG_TOP_LIMIT: data = CFG_DATA_W'($urandom_range(ROW_LAST));
            default:       data = CFG_DATA_W'($urandom_range(16'hFFFF));
          endcase
        end
        write_reg(idx, data);
      end
      run_groups(1);
    end
  endtask

  initial begin
    reset_plot_state();
    // Synchronous reset, released on a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_idling(33, 78);
    test_directed_rails();
    test_register_extremes();
    test_random_sweep(33, 78, 57);
    test_random_sweep(78, 33, 57);
    test_random_sweep(0, 0, 57);

    drain_pipeline();
    if (err_count == 0) begin
      $display("PASS sweep_trace_segment_generator_unit");
    end else begin
      $display("FAIL sweep_trace_segment_generator_unit");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/stsg_pkg.sv
hw/rtl/stsg_decim.sv
hw/rtl/stsg_plot.sv
hw/rtl/sweep_trace_segment_generator_unit.sv
hw/rtl/stsg_checker.sv
sim/tb_top.sv
